// ===== rtl/oabl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oabl_pkg
// shared types and constants for the octree ancestor block lookup
// ----------------------------------------------------------------------------
package oabl_pkg;

    localparam int LEVEL_W = 5;
    localparam int COORD_W = 31;
    localparam int SLOT_W  = 6;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    // input tdata layout, lowest bit first
    localparam int IN_DATA_W = 104;
    localparam int SLOT_LSB  = 0;
    localparam int LEVEL_LSB = 6;
    localparam int X1_LSB    = 11;
    localparam int X2_LSB    = 42;
    localparam int X3_LSB    = 73;

    localparam int OUT_DATA_W = 8;

    // item kinds carried on input tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // register map
    localparam int  APB_ADDR_W      = 3;
    localparam int  REG_IDX_W       = 1;
    localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] x3;
    } t_loc;

    // controller to datapath
    typedef struct packed {
        logic load;      // write one table entry
        logic start;     // capture query and restart the scan
        logic step;      // advance the scan by one entry
        logic load_out;  // move the result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic exhausted;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/oabl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oabl_ctrl
// sequencer for table loads and the entry-by-entry query scan
// ----------------------------------------------------------------------------
module oabl_ctrl
    import oabl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_func,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_finish;

    assign w_finish = i_sts.hit | i_sts.exhausted;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_func == FUNC_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (w_finish) begin
                    if (i_sts.out_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/oabl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oabl_datapath
// location table, scan counter, ancestor compare and result register
// ----------------------------------------------------------------------------
module oabl_datapath
    import oabl_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [COUNT_W-1:0] i_entry_count,
    input  logic [SLOT_W-1:0]  i_slot,
    input  t_loc               i_loc,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_out_found,
    output logic [INDEX_W-1:0] o_out_index
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SCW   = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int CMW   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int OW    = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

    t_loc              r_mem [MAX_ENTRIES];

    t_loc              r_query;
    t_loc              r_rd_entry;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_rd_vld;
    logic [CNT_W-1:0]  r_addr;
    logic [CNT_W-1:0]  r_limit;

    logic              r_out_vld;
    logic              r_out_found;
    logic [INDEX_W-1:0] r_out_idx;

    logic [SCW-1:0]    w_slot_ext;
    logic              w_slot_ok;
    logic [CMW-1:0]    w_count_ext;
    logic [CMW-1:0]    w_limit;
    logic              w_more;
    logic [LEVEL_W-1:0] w_shift;
    logic              w_match;
    logic [OW-1:0]     w_idx_ext;

    assign w_slot_ext  = SCW'(i_slot);
    assign w_slot_ok   = w_slot_ext < SCW'(MAX_ENTRIES);
    assign w_count_ext = CMW'(i_entry_count);
    assign w_limit     = (w_count_ext > CMW'(MAX_ENTRIES)) ? CMW'(MAX_ENTRIES) : w_count_ext;
    assign w_more      = r_addr < r_limit;

    // entry covers query when its level is not deeper and shifted coordinates agree
    assign w_shift = r_query.level - r_rd_entry.level;
    assign w_match = (r_rd_entry.level <= r_query.level) &&
                     ((r_query.x1 >> w_shift) == r_rd_entry.x1) &&
                     ((r_query.x2 >> w_shift) == r_rd_entry.x2) &&
                     ((r_query.x3 >> w_shift) == r_rd_entry.x3);

    assign o_sts.hit       = r_rd_vld & w_match;
    assign o_sts.exhausted = ~r_rd_vld & ~w_more;
    assign o_sts.out_free  = ~r_out_vld | i_out_ready;

    assign w_idx_ext = OW'(r_rd_idx);

    // table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_slot_ok) begin
            r_mem[w_slot_ext[IDX_W-1:0]] <= i_loc;
        end
        if (i_cmd.step && w_more) begin
            r_rd_entry <= r_mem[r_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_query <= i_loc;
            r_limit <= w_limit[CNT_W-1:0];
        end
        if (i_cmd.step && w_more) begin
            r_rd_idx <= r_addr[IDX_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_found <= o_sts.hit;
            r_out_idx   <= o_sts.hit ? w_idx_ext[INDEX_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_addr   <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.step) begin
                r_rd_vld <= w_more;
                if (w_more) begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_found = r_out_found;
    assign o_out_index = r_out_idx;

endmodule

// ===== rtl/octree_ancestor_block_lookup.sv =====
`timescale 1ns / 1ps
// Octree ancestor block lookup. Load items (tuser = 0) write one location
// into the table and produce no result. A query item (tuser = 1) scans
// table entries from index 0 upward, one entry per cycle through the single
// read port of the table memory, and returns the first entry that is the
// query block or one of its ancestors. The scan covers L entries, where L
// is entry_count limited to MAX_ENTRIES. The result is loaded into the
// output register once it is free, and the next item is taken in the cycle
// after that.
// A result waiting on the output does not hold off loads or the next query
// scan, only the hand-over of that query's own result.
// ----------------------------------------------------------------------------
// octree_ancestor_block_lookup
// top level with stream ports, register port and the lookup core
// ----------------------------------------------------------------------------
module octree_ancestor_block_lookup
    import oabl_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // entry_slot, loc_level, loc_x1, loc_x2, loc_x3
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // block_index, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // found
    output logic                  m_axis_tuser,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [COUNT_W-1:0]   r_entry_count;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_in_ready;
    t_cmd                 w_cmd;
    t_sts                 w_sts;
    t_loc                 w_loc;
    logic [SLOT_W-1:0]    w_slot;
    logic                 w_found;
    logic [INDEX_W-1:0]   w_index;

    // register port
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (psel && penable && pwrite && pready &&
                     w_reg_idx == REG_ENTRY_COUNT) begin
            r_entry_count <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (w_reg_idx == REG_ENTRY_COUNT) ? 32'(r_entry_count) : '0;

    // input unpack
    assign w_slot    = s_axis_tdata[SLOT_LSB +: SLOT_W];
    assign w_loc.level = s_axis_tdata[LEVEL_LSB +: LEVEL_W];
    assign w_loc.x1  = s_axis_tdata[X1_LSB +: COORD_W];
    assign w_loc.x2  = s_axis_tdata[X2_LSB +: COORD_W];
    assign w_loc.x3  = s_axis_tdata[X3_LSB +: COORD_W];

    assign s_axis_tready = w_in_ready;

    oabl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_func  (s_axis_tuser),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    oabl_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_entry_count (r_entry_count),
        .i_slot        (w_slot),
        .i_loc         (w_loc),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_found   (w_found),
        .o_out_index   (w_index)
    );

    assign m_axis_tdata = OUT_DATA_W'(w_index);
    assign m_axis_tuser = w_found;

endmodule

// ===== test/tb_octree_ancestor_block_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_octree_ancestor_block_lookup
// self-checking bench: table loads and ancestor lookups over the stream ports,
// entry_count written over apb between phases, results checked in order
// against a cycle-free predictor of the table search
// ----------------------------------------------------------------------------
module tb_octree_ancestor_block_lookup;
    import oabl_pkg::*;

    localparam int TAB_DEPTH     = 64;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 124;

    typedef struct {
        bit              found;
        bit [INDEX_W-1:0] index;
    } t_lookup;

    class lookup_scoreboard;
        t_loc             tab [TAB_DEPTH];
        bit [COUNT_W-1:0] entry_count;
        t_lookup          expected_lookups [$];
        int               errors;
        int               loads;
        int               lookups;
        int               hits;
        int               count_writes;

        function new();
            entry_count = '0;
            errors = 0;
            loads = 0;
            lookups = 0;
            hits = 0;
            count_writes = 0;
        endfunction

        function void set_count(bit [COUNT_W-1:0] value);
            entry_count = value;
            count_writes++;
        endfunction

        function int active_entries();
            return (entry_count > TAB_DEPTH) ? TAB_DEPTH : int'(entry_count);
        endfunction

        // first entry that is the query block or one of its ancestors
        function t_lookup find_container(t_loc q);
            t_lookup r;
            int      shift;
            r.found = 1'b0;
            r.index = '0;
            for (int m = 0; m < active_entries(); m++) begin
                if (!r.found && tab[m].level <= q.level) begin
                    shift = int'(q.level) - int'(tab[m].level);
                    if ((q.x1 >> shift) == tab[m].x1 && (q.x2 >> shift) == tab[m].x2 &&
                        (q.x3 >> shift) == tab[m].x3) begin
                        r.found = 1'b1;
                        r.index = m[INDEX_W-1:0];
                    end
                end
            end
            return r;
        endfunction

        function void note_item(logic func, bit [SLOT_W-1:0] slot, t_loc loc);
            t_lookup r;
            if (func == FUNC_LOAD) begin
                tab[slot] = loc;
                loads++;
            end else begin
                r = find_container(loc);
                expected_lookups.push_back(r);
                lookups++;
                if (r.found) hits++;
            end
        endfunction

        function void check_result(logic found, logic [INDEX_W-1:0] index,
                                   logic [OUT_DATA_W-INDEX_W-1:0] fill);
            t_lookup e;
            if (expected_lookups.size() == 0) begin
                $error("unexpected result transfer: found %0d block_index %0d", found, index);
                errors++;
                return;
            end
            e = expected_lookups.pop_front();
            if (found !== e.found) begin
                $error("found: expected %0d, got %0d", e.found, found);
                errors++;
            end
            if (index !== e.index) begin
                $error("block_index: expected %0d, got %0d", e.index, index);
                errors++;
            end
            if (fill !== '0) begin
                $error("tdata fill: expected 0, got %0h", fill);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    lookup_scoreboard sb;
    bit               slot_loaded [TAB_DEPTH];
    int               idle_pct = 30;
    int               hold_requests = 0;
    int               hold_granted = 0;
    int               hold_left = 0;
    int               cycles = 0;

    octree_ancestor_block_lookup #(
        .MAX_ENTRIES(TAB_DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: check transfers, random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser, m_axis_tdata[INDEX_W-1:0],
                            m_axis_tdata[OUT_DATA_W-1:INDEX_W]);
        end
        if (hold_granted != hold_requests) begin
            hold_granted = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    function automatic t_loc loc(int lvl, logic [31:0] a, logic [31:0] b, logic [31:0] c);
        t_loc l;
        l.level = lvl[LEVEL_W-1:0];
        l.x1 = a[COORD_W-1:0];
        l.x2 = b[COORD_W-1:0];
        l.x3 = c[COORD_W-1:0];
        return l;
    endfunction

    function automatic logic [COORD_W-1:0] low_mask(int n);
        logic [63:0] m;
        m = (64'h1 << n) - 64'h1;
        return m[COORD_W-1:0];
    endfunction

    // a block d levels finer inside p, random low bits
    function automatic t_loc descend(t_loc p, int d);
        t_loc c;
        c.level = p.level + d[LEVEL_W-1:0];
        c.x1 = (p.x1 << d) | (COORD_W'($urandom) & low_mask(d));
        c.x2 = (p.x2 << d) | (COORD_W'($urandom) & low_mask(d));
        c.x3 = (p.x3 << d) | (COORD_W'($urandom) & low_mask(d));
        return c;
    endfunction

    function automatic t_loc fresh_loc();
        t_loc e;
        e.level = LEVEL_W'($urandom_range(31));
        if ($urandom_range(3) == 0) begin
            e.x1 = COORD_W'($urandom);
            e.x2 = COORD_W'($urandom);
            e.x3 = COORD_W'($urandom);
        end else begin
            e.x1 = COORD_W'($urandom) & low_mask(e.level);
            e.x2 = COORD_W'($urandom) & low_mask(e.level);
            e.x3 = COORD_W'($urandom) & low_mask(e.level);
        end
        return e;
    endfunction

    // table entries: some parents or children of stored blocks, the rest random
    function automatic t_loc make_entry();
        t_loc p;
        t_loc e;
        int   s;
        int   d;
        if ($urandom_range(99) < 45) begin
            do s = $urandom_range(TAB_DEPTH - 1); while (!slot_loaded[s]);
            p = sb.tab[s];
            if ($urandom_range(1) == 1) begin
                e = descend(p, $urandom_range(31 - int'(p.level)));
            end else begin
                d = $urandom_range(int'(p.level));
                e.level = p.level - d[LEVEL_W-1:0];
                e.x1 = p.x1 >> d;
                e.x2 = p.x2 >> d;
                e.x3 = p.x3 >> d;
            end
        end else begin
            e = fresh_loc();
        end
        return e;
    endfunction

    // queries: mostly inside a searched entry, some near misses, some random
    function automatic t_loc make_query();
        t_loc q;
        t_loc p;
        int   r;
        int   n;
        r = $urandom_range(99);
        n = sb.active_entries();
        if (n == 0 || r >= 85) return fresh_loc();
        p = sb.tab[$urandom_range(n - 1)];
        q = descend(p, $urandom_range(31 - int'(p.level)));
        if (r >= 70) begin
            case ($urandom_range(3))
                0: q.x1[$urandom_range(COORD_W - 1)] ^= 1'b1;
                1: q.x2[$urandom_range(COORD_W - 1)] ^= 1'b1;
                2: q.x3[$urandom_range(COORD_W - 1)] ^= 1'b1;
                default: q.level[$urandom_range(LEVEL_W - 1)] ^= 1'b1;
            endcase
        end
        return q;
    endfunction

    task automatic push_item(logic func, bit [SLOT_W-1:0] slot, t_loc l);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {l.x3, l.x2, l.x1, l.level, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(func, slot, l);
        if (func == FUNC_LOAD) slot_loaded[slot] = 1'b1;
    endtask

    task automatic push_query(t_loc l);
        push_item(FUNC_QUERY, SLOT_W'($urandom), l);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_entry_count(bit [COUNT_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_ENTRY_COUNT, 2'b00};
        pwdata <= {{(32 - COUNT_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_count(value);
    endtask

    initial begin
        int count_plan [10];
        int order [TAB_DEPTH];
        int j;
        int tmp;
        int cnt;

        sb = new();
        count_plan = '{64, 127, 1, 65, 0, -1, 100, 32, -1, 64};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty search, then extreme entries and a small hierarchy
        push_query(loc(31, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        push_item(FUNC_LOAD, 6'd0, loc(0, 0, 0, 0));
        push_item(FUNC_LOAD, 6'd1, loc(31, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        push_item(FUNC_LOAD, 6'd2, loc(3, 5, 2, 7));
        push_item(FUNC_LOAD, 6'd3, loc(5, 23, 8, 29));
        push_item(FUNC_LOAD, 6'd63, loc(16, 32'h5555, 32'h2AAA, 32'hFFFF));
        wait_idle();
        write_entry_count(7'd1);
        push_query(loc(31, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        push_query(loc(0, 0, 0, 0));
        push_item(FUNC_LOAD, 6'd0, loc(31, 1, 1, 1));
        wait_idle();
        write_entry_count(7'd4);
        push_query(loc(5, 21, 8, 29));
        push_query(loc(5, 23, 8, 29));
        push_query(loc(31, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        push_query(loc(30, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h3FFF_FFFF));
        push_query(loc(2, 2, 1, 3));
        push_query(loc(31, 1, 1, 1));

        // fill the whole table in random order, lookups mixed in
        for (int i = 0; i < TAB_DEPTH; i++) order[i] = i;
        for (int i = TAB_DEPTH - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < TAB_DEPTH; i++) begin
            if ($urandom_range(99) < 30) push_query(make_query());
            push_item(FUNC_LOAD, order[i][SLOT_W-1:0], make_entry());
        end

        for (int ph = 0; ph < 10; ph++) begin
            wait_idle();
            cnt = (count_plan[ph] < 0) ? $urandom_range(TAB_DEPTH) : count_plan[ph];
            write_entry_count(cnt[COUNT_W-1:0]);
            idle_pct = (ph == 3) ? 0 : 30;
            if (ph == 1) hold_requests++;
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(99) < 25) begin
                    push_item(FUNC_LOAD, SLOT_W'($urandom), make_entry());
                end else begin
                    push_query(make_query());
                end
            end
        end

        wait_idle();
        $display("run covered %0d table loads and %0d lookups, %0d of them found",
                 sb.loads, sb.lookups, sb.hits);
        $display("entry_count written %0d times, %0d mismatches", sb.count_writes, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/oabl_pkg.sv
rtl/oabl_ctrl.sv
rtl/oabl_datapath.sv
rtl/octree_ancestor_block_lookup.sv
test/tb_octree_ancestor_block_lookup.sv
